@@ rtl/akd_pkg.sv @@
`default_nettype none

package akd_pkg;

    // Fixed layout of one anchor's values: ten point offsets, then objectness.
    localparam int OFFSET_COUNT      = 10;
    localparam int POINT_FIELDS      = 11;
    localparam int POINT_COUNT       = 5;
    localparam int LAST_POINT_NUMBER = POINT_COUNT - 1;

    localparam int FEATURE_W = 16;
    localparam int COORD_W   = 24;
    localparam int POINT_W   = 3;
    localparam int ANCHOR_W  = 14;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 24;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

    // log2 of the stride of each grid level: 8, 16 and 32.
    localparam logic [2:0] STRIDE_SHIFT_L0 = 3'd3;
    localparam logic [2:0] STRIDE_SHIFT_L1 = 3'd4;
    localparam logic [2:0] STRIDE_SHIFT_L2 = 3'd5;

    typedef enum logic [1:0] {
        LEVEL_S8  = 2'd0,
        LEVEL_S16 = 2'd1,
        LEVEL_S32 = 2'd2,
        LEVEL_BAD = 2'd3
    } t_level;

    typedef enum logic [1:0] {
        CFG_INVERSE_SCALE    = 2'd0,
        CFG_SHIFT_X          = 2'd1,
        CFG_SHIFT_Y          = 2'd2,
        CFG_CONFIDENCE_FLOOR = 2'd3
    } t_cfg_index;

    // Per-result tag that travels alongside the coordinate pipeline.
    typedef struct packed {
        logic [POINT_W-1:0]          point_number;
        logic                        last_point;
        logic [ANCHOR_W-1:0]         anchor_number;
        logic                        class_index;
        logic                        color_index;
        logic signed [FEATURE_W-1:0] objectness;
    } t_meta;

endpackage

`default_nettype wire

@@ rtl/anchor_keypoint_decoder_core.sv @@
`default_nettype none

// Keypoint decoder for an anchor-free detector head.
// Input channel: one signed Q8.8 head value per request (i_feature_valid /
// o_feature_ready), anchor after anchor, each anchor made of ten point offsets,
// objectness, the color scores and the class scores. The block tracks the grid
// position itself, row by row over the stride 8, 16 and 32 levels.
// Output channel: five keypoint requests per kept anchor (o_point_valid /
// i_point_ready), keypoint 0 to 4, with o_last_point on the fifth.
// Throughput: one head value per cycle while o_feature_ready is high. Results pass
// the snapshot, grid scaling, multiply and round-and-saturate registers; after the
// first, the other four follow one per cycle unless the receiver stalls.
// A single anchor snapshot holds the results being sent; when the receiver
// stalls long enough that the snapshot is still busy as the next anchor
// completes, o_feature_ready drops on that anchor's last value only.
// A stalled result holds in the output register while the pipeline freezes.
// Reset returns the grid walk to the first anchor, empties the pipeline and
// loads the configuration defaults. Configuration writes take effect at once.
module anchor_keypoint_decoder_core #(
    parameter int INPUT_SIDE   = 640,
    parameter int COLOR_SCORES = 2,
    parameter int CLASS_SCORES = 2
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_we,
    input  wire logic [1:0]                           i_cfg_index,
    input  wire logic [akd_pkg::CFG_W-1:0]            i_cfg_data,

    input  wire logic                                 i_feature_valid,
    output logic                                      o_feature_ready,
    input  wire logic signed [akd_pkg::FEATURE_W-1:0] i_feature_value,

    output logic                                      o_point_valid,
    input  wire logic                                 i_point_ready,
    output logic signed [akd_pkg::COORD_W-1:0]        o_point_x,
    output logic signed [akd_pkg::COORD_W-1:0]        o_point_y,
    output logic [akd_pkg::POINT_W-1:0]               o_point_number,
    output logic [akd_pkg::ANCHOR_W-1:0]              o_anchor_number,
    output logic                                      o_class_index,
    output logic                                      o_color_index,
    output logic signed [akd_pkg::FEATURE_W-1:0]      o_objectness,
    output logic                                      o_last_point
);

    localparam int ANCHOR_ELEMENTS = akd_pkg::POINT_FIELDS + COLOR_SCORES + CLASS_SCORES;
    localparam int POS_W   = $clog2(ANCHOR_ELEMENTS);
    localparam int CELLS0  = INPUT_SIDE / 8;
    localparam int CELLS1  = INPUT_SIDE / 16;
    localparam int CELLS2  = INPUT_SIDE / 32;
    localparam int GRID_W  = $clog2(CELLS0);
    localparam int CLR_W   = (COLOR_SCORES > 1) ? $clog2(COLOR_SCORES) : 1;
    localparam int CLS_W   = (CLASS_SCORES > 1) ? $clog2(CLASS_SCORES) : 1;
    localparam int SUM_W   = (GRID_W + 10 > 17) ? GRID_W + 10 : 17;
    localparam int NET_W   = SUM_W + 5;
    localparam int PROD_W  = NET_W + akd_pkg::SCALE_W + 1;
    localparam int RND_W   = PROD_W - 8;
    localparam int SH_W    = RND_W + 1;
    localparam int CLASS_START = akd_pkg::POINT_FIELDS + COLOR_SCORES;

    // Configuration registers.
    logic [akd_pkg::SCALE_W-1:0]          r_inverse_scale;
    logic signed [akd_pkg::COORD_W-1:0]   r_shift_x;
    logic signed [akd_pkg::COORD_W-1:0]   r_shift_y;
    logic signed [akd_pkg::FEATURE_W-1:0] r_confidence_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse_scale    <= akd_pkg::SCALE_W'(256);
            r_shift_x          <= '0;
            r_shift_y          <= '0;
            r_confidence_floor <= akd_pkg::FEATURE_W'(51);
        end else if (i_cfg_we) begin
            unique case (akd_pkg::t_cfg_index'(i_cfg_index))
                akd_pkg::CFG_INVERSE_SCALE:
                    r_inverse_scale <= i_cfg_data[akd_pkg::SCALE_W-1:0];
                akd_pkg::CFG_SHIFT_X:
                    r_shift_x <= $signed(i_cfg_data);
                akd_pkg::CFG_SHIFT_Y:
                    r_shift_y <= $signed(i_cfg_data);
                akd_pkg::CFG_CONFIDENCE_FLOOR:
                    r_confidence_floor <= $signed(i_cfg_data[akd_pkg::FEATURE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Anchor collection.
    logic [POS_W-1:0]                     r_pos;
    logic [GRID_W-1:0]                    r_col;
    logic [GRID_W-1:0]                    r_row;
    akd_pkg::t_level                      r_level;
    logic [akd_pkg::ANCHOR_W-1:0]         r_anchor;
    logic signed [akd_pkg::FEATURE_W-1:0] r_off [akd_pkg::OFFSET_COUNT];
    logic signed [akd_pkg::FEATURE_W-1:0] r_obj;
    logic signed [akd_pkg::FEATURE_W-1:0] r_clr_score;
    logic [CLR_W-1:0]                     r_clr_idx;
    logic signed [akd_pkg::FEATURE_W-1:0] r_cls_score;
    logic [CLS_W-1:0]                     r_cls_idx;

    // Snapshot of a kept anchor while its five results go out.
    logic                                 r_snap_busy;
    logic [akd_pkg::POINT_W-1:0]          r_snap_pt;
    logic signed [akd_pkg::FEATURE_W-1:0] r_snap_off [akd_pkg::OFFSET_COUNT];
    logic [GRID_W-1:0]                    r_snap_col;
    logic [GRID_W-1:0]                    r_snap_row;
    logic [2:0]                           r_snap_shift;
    logic [akd_pkg::ANCHOR_W-1:0]         r_snap_anchor;
    logic                                 r_snap_cls;
    logic                                 r_snap_clr;
    logic signed [akd_pkg::FEATURE_W-1:0] r_snap_obj;

    logic                                 w_accept;
    logic                                 w_last;
    logic                                 w_keep;
    logic                                 w_is_clr;
    logic                                 w_is_cls;
    logic [CLR_W-1:0]                     w_clr_k;
    logic [CLS_W-1:0]                     w_cls_k;
    logic signed [akd_pkg::FEATURE_W-1:0] n_clr_score;
    logic [CLR_W-1:0]                     n_clr_idx;
    logic signed [akd_pkg::FEATURE_W-1:0] n_cls_score;
    logic [CLS_W-1:0]                     n_cls_idx;
    logic [GRID_W:0]                      w_cells;
    logic [2:0]                           w_stride_shift;
    logic [GRID_W:0]                      w_col_inc;
    logic [GRID_W:0]                      w_row_inc;

    assign o_feature_ready = !(w_last && r_snap_busy);
    assign w_accept        = i_feature_valid && o_feature_ready;
    assign w_last          = (r_pos == POS_W'(ANCHOR_ELEMENTS - 1));
    assign w_keep          = w_accept && w_last && (r_obj >= r_confidence_floor);
    assign w_is_clr        = (r_pos >= POS_W'(akd_pkg::POINT_FIELDS)) &&
                             (r_pos < POS_W'(CLASS_START));
    assign w_is_cls        = (r_pos >= POS_W'(CLASS_START));
    assign w_clr_k         = CLR_W'(r_pos - POS_W'(akd_pkg::POINT_FIELDS));
    assign w_cls_k         = CLS_W'(r_pos - POS_W'(CLASS_START));
    assign w_col_inc       = {1'b0, r_col} + (GRID_W+1)'(1);
    assign w_row_inc       = {1'b0, r_row} + (GRID_W+1)'(1);

    always_comb begin
        case (r_level)
            akd_pkg::LEVEL_S16: begin
                w_cells        = (GRID_W+1)'(CELLS1);
                w_stride_shift = akd_pkg::STRIDE_SHIFT_L1;
            end
            akd_pkg::LEVEL_S32: begin
                w_cells        = (GRID_W+1)'(CELLS2);
                w_stride_shift = akd_pkg::STRIDE_SHIFT_L2;
            end
            default: begin
                w_cells        = (GRID_W+1)'(CELLS0);
                w_stride_shift = akd_pkg::STRIDE_SHIFT_L0;
            end
        endcase
    end

    // First maximum wins: the first score of a group always loads.
    always_comb begin
        n_clr_score = r_clr_score;
        n_clr_idx   = r_clr_idx;
        n_cls_score = r_cls_score;
        n_cls_idx   = r_cls_idx;
        if (w_accept && w_is_clr &&
            (w_clr_k == '0 || i_feature_value > r_clr_score)) begin
            n_clr_score = i_feature_value;
            n_clr_idx   = w_clr_k;
        end
        if (w_accept && w_is_cls &&
            (w_cls_k == '0 || i_feature_value > r_cls_score)) begin
            n_cls_score = i_feature_value;
            n_cls_idx   = w_cls_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_level   <= akd_pkg::LEVEL_S8;
            r_anchor  <= '0;
            r_clr_idx <= '0;
            r_cls_idx <= '0;
        end else begin
            r_clr_idx <= n_clr_idx;
            r_cls_idx <= n_cls_idx;
            if (w_accept) begin
                if (w_last) begin
                    r_pos    <= '0;
                    r_anchor <= r_anchor + akd_pkg::ANCHOR_W'(1);
                    if (w_col_inc >= w_cells) begin
                        r_col <= '0;
                        if (w_row_inc >= w_cells) begin
                            r_row <= '0;
                            unique case (r_level)
                                akd_pkg::LEVEL_S8:  r_level <= akd_pkg::LEVEL_S16;
                                akd_pkg::LEVEL_S16: r_level <= akd_pkg::LEVEL_S32;
                                default: begin
                                    r_level  <= akd_pkg::LEVEL_S8;
                                    r_anchor <= '0;
                                end
                            endcase
                        end else begin
                            r_row <= GRID_W'(w_row_inc);
                        end
                    end else begin
                        r_col <= GRID_W'(w_col_inc);
                    end
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // Offsets enter a shift line, so x0 sits at the front once all ten are in.
    always_ff @(posedge i_clk) begin
        r_clr_score <= n_clr_score;
        r_cls_score <= n_cls_score;
        if (w_accept && r_pos < POS_W'(akd_pkg::OFFSET_COUNT)) begin
            for (int i = 0; i < akd_pkg::OFFSET_COUNT - 1; i++) begin
                r_off[i] <= r_off[i+1];
            end
            r_off[akd_pkg::OFFSET_COUNT-1] <= i_feature_value;
        end
        if (w_accept && r_pos == POS_W'(akd_pkg::OFFSET_COUNT)) begin
            r_obj <= i_feature_value;
        end
    end

    // Result pipeline: snapshot, grid scaling, multiply, round and saturate.
    logic                       w_advance;
    logic                       r_s1_valid;
    logic signed [NET_W-1:0]    r_s1_x;
    logic signed [NET_W-1:0]    r_s1_y;
    akd_pkg::t_meta             r_s1_meta;
    logic                       r_s2_valid;
    logic signed [PROD_W-1:0]   r_s2_x;
    logic signed [PROD_W-1:0]   r_s2_y;
    akd_pkg::t_meta             r_s2_meta;
    logic                       r_out_valid;
    logic signed [akd_pkg::COORD_W-1:0] r_out_x;
    logic signed [akd_pkg::COORD_W-1:0] r_out_y;
    akd_pkg::t_meta             r_out_meta;

    logic signed [SUM_W-1:0]    w_sum_x;
    logic signed [SUM_W-1:0]    w_sum_y;
    logic signed [NET_W-1:0]    w_net_x;
    logic signed [NET_W-1:0]    w_net_y;
    akd_pkg::t_meta             w_snap_meta;
    logic signed [RND_W-1:0]    w_rnd_x;
    logic signed [RND_W-1:0]    w_rnd_y;
    logic signed [SH_W-1:0]     w_img_x;
    logic signed [SH_W-1:0]     w_img_y;
    logic signed [akd_pkg::COORD_W-1:0] w_sat_x;
    logic signed [akd_pkg::COORD_W-1:0] w_sat_y;
    logic signed [PROD_W-1:0]   w_scale;

    assign w_advance = !(r_out_valid && !i_point_ready);

    assign w_sum_x = SUM_W'(r_snap_off[0]) + SUM_W'($signed({1'b0, r_snap_col, 8'h00}));
    assign w_sum_y = SUM_W'(r_snap_off[1]) + SUM_W'($signed({1'b0, r_snap_row, 8'h00}));
    assign w_net_x = NET_W'(w_sum_x) <<< r_snap_shift;
    assign w_net_y = NET_W'(w_sum_y) <<< r_snap_shift;

    always_comb begin
        w_snap_meta.point_number  = r_snap_pt;
        w_snap_meta.last_point    = (r_snap_pt == akd_pkg::POINT_W'(akd_pkg::LAST_POINT_NUMBER));
        w_snap_meta.anchor_number = r_snap_anchor;
        w_snap_meta.class_index   = r_snap_cls;
        w_snap_meta.color_index   = r_snap_clr;
        w_snap_meta.objectness    = r_snap_obj;
    end

    assign w_scale = PROD_W'($signed({1'b0, r_inverse_scale}));

    // Round half up from Q.16 to Q.8; the arithmetic shift floors.
    assign w_rnd_x = RND_W'((r_s2_x + PROD_W'(128)) >>> 8);
    assign w_rnd_y = RND_W'((r_s2_y + PROD_W'(128)) >>> 8);
    assign w_img_x = SH_W'(w_rnd_x) + SH_W'(r_shift_x);
    assign w_img_y = SH_W'(w_rnd_y) + SH_W'(r_shift_y);

    always_comb begin
        if (w_img_x > SH_W'(akd_pkg::COORD_MAX)) begin
            w_sat_x = akd_pkg::COORD_MAX;
        end else if (w_img_x < SH_W'(akd_pkg::COORD_MIN)) begin
            w_sat_x = akd_pkg::COORD_MIN;
        end else begin
            w_sat_x = akd_pkg::COORD_W'(w_img_x);
        end
        if (w_img_y > SH_W'(akd_pkg::COORD_MAX)) begin
            w_sat_y = akd_pkg::COORD_MAX;
        end else if (w_img_y < SH_W'(akd_pkg::COORD_MIN)) begin
            w_sat_y = akd_pkg::COORD_MIN;
        end else begin
            w_sat_y = akd_pkg::COORD_W'(w_img_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_busy <= 1'b0;
            r_snap_pt   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_keep) begin
                r_snap_busy <= 1'b1;
                r_snap_pt   <= '0;
            end else if (r_snap_busy && w_advance) begin
                r_snap_pt <= r_snap_pt + akd_pkg::POINT_W'(1);
                if (r_snap_pt == akd_pkg::POINT_W'(akd_pkg::LAST_POINT_NUMBER)) begin
                    r_snap_busy <= 1'b0;
                end
            end
            if (w_advance) begin
                r_s1_valid  <= r_snap_busy;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            for (int i = 0; i < akd_pkg::OFFSET_COUNT; i++) begin
                r_snap_off[i] <= r_off[i];
            end
            r_snap_col    <= r_col;
            r_snap_row    <= r_row;
            r_snap_shift  <= w_stride_shift;
            r_snap_anchor <= r_anchor;
            r_snap_cls    <= n_cls_idx[0];
            r_snap_clr    <= n_clr_idx[0];
            r_snap_obj    <= r_obj;
        end else if (r_snap_busy && w_advance) begin
            // Move the next point's x and y to the front.
            for (int i = 0; i < akd_pkg::OFFSET_COUNT - 2; i++) begin
                r_snap_off[i] <= r_snap_off[i+2];
            end
        end
        if (w_advance) begin
            r_s1_x     <= w_net_x;
            r_s1_y     <= w_net_y;
            r_s1_meta  <= w_snap_meta;
            r_s2_x     <= PROD_W'(r_s1_x) * w_scale;
            r_s2_y     <= PROD_W'(r_s1_y) * w_scale;
            r_s2_meta  <= r_s1_meta;
            r_out_x    <= w_sat_x;
            r_out_y    <= w_sat_y;
            r_out_meta <= r_s2_meta;
        end
    end

    assign o_point_valid   = r_out_valid;
    assign o_point_x       = r_out_x;
    assign o_point_y       = r_out_y;
    assign o_point_number  = r_out_meta.point_number;
    assign o_anchor_number = r_out_meta.anchor_number;
    assign o_class_index   = r_out_meta.class_index;
    assign o_color_index   = r_out_meta.color_index;
    assign o_objectness    = r_out_meta.objectness;
    assign o_last_point    = r_out_meta.last_point;

endmodule

`default_nettype wire

@@ rtl/akd_checker.sv @@
`default_nettype none

module akd_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 o_point_valid,
    input wire logic                                 i_point_ready,
    input wire logic signed [akd_pkg::COORD_W-1:0]   o_point_x,
    input wire logic signed [akd_pkg::COORD_W-1:0]   o_point_y,
    input wire logic [akd_pkg::POINT_W-1:0]          o_point_number,
    input wire logic [akd_pkg::ANCHOR_W-1:0]         o_anchor_number,
    input wire logic                                 o_last_point
);

    // A stalled result request keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && !i_point_ready |=>
            o_point_valid && $stable(o_point_x) && $stable(o_point_y) &&
            $stable(o_point_number) && $stable(o_anchor_number))
        else $error("result changed while stalled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |->
            (o_last_point == (o_point_number ==
                              akd_pkg::POINT_W'(akd_pkg::LAST_POINT_NUMBER))))
        else $error("last point flag does not match point number");

    a_point_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |->
            o_point_number <= akd_pkg::POINT_W'(akd_pkg::LAST_POINT_NUMBER))
        else $error("point number out of range");

    // The five points of an anchor leave back to back under the same anchor number.
    a_point_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && i_point_ready && !o_last_point |=>
            o_point_valid &&
            o_point_number == $past(o_point_number) + akd_pkg::POINT_W'(1) &&
            $stable(o_anchor_number))
        else $error("anchor point run broken");

endmodule

bind anchor_keypoint_decoder_core akd_checker u_akd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_point_valid   (o_point_valid),
    .i_point_ready   (i_point_ready),
    .o_point_x       (o_point_x),
    .o_point_y       (o_point_y),
    .o_point_number  (o_point_number),
    .o_anchor_number (o_anchor_number),
    .o_last_point    (o_last_point)
);

`default_nettype wire
